@@ sv/spiee_pkg.sv @@
// shared types and constants for the spi eeprom command sequencer
// no dependencies; used by every module of the block
package spiee_pkg;

  typedef enum logic [1:0] {
    OP_WRITE_BYTE = 2'd0,
    OP_READ_BYTE  = 2'd1,
    OP_CHIP_ERASE = 2'd2,
    OP_STATUS     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_SHIFT   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_AWAIT   = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    CMD_POLL,
    CMD_WRITE,
    CMD_READ,
    CMD_ERASE,
    CMD_SHIFT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic        pre_rel;
    logic        end_rel;
    logic [15:0] addr;
    logic [7:0]  data;
  } cmd_t;

  localparam logic [7:0] SPI_WREN  = 8'h06;
  localparam logic [7:0] SPI_RDSR  = 8'h05;
  localparam logic [7:0] SPI_WRITE = 8'h02;
  localparam logic [7:0] SPI_READ  = 8'h03;
  localparam logic [7:0] SPI_CE    = 8'hC7;
  localparam int unsigned WIP_BIT  = 0;

  localparam int unsigned CMD_Q_DEPTH = 2;

endpackage

@@ sv/spi_eeprom_command_sequencer_core.sv @@
// top level of the spi eeprom command sequencer
// instantiates spiee_front, spiee_cmd_fifo and spiee_back; uses spiee_pkg
//
// Turns byte-level write, read and chip-erase requests, plus status replies
// from the device, into spi byte actions for a 25xx-style eeprom. The front
// end takes one input transaction per cycle while its two-entry command
// queue has room; every input that yields output becomes one queued command.
// The back end plays a command out as 1 to 7 output transactions, one per
// cycle while out_ready_i is high, the last carrying end_of_run_o. Counted
// in actions, a command takes 4 or 5 for a new transfer, 4 for a repeated
// poll, 3 to 7 once the device is ready, 1 or 2 for a continuation byte.
// Inputs that cause no action (a stray status reply, a request while a
// reply is awaited) queue no command.
module spi_eeprom_command_sequencer_core #(
  parameter int unsigned PAGE_BYTES = 128,
  parameter int unsigned ADDR_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic        first_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  action_o,
  output logic [7:0]  tx_byte_o,
  output logic        end_of_run_o
);

  logic            f_valid, f_ready;
  spiee_pkg::cmd_t f_cmd;
  logic            q_valid, q_pop;
  spiee_pkg::cmd_t q_cmd;

  spiee_front #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .address_i  (address_i),
    .data_i     (data_i),
    .first_i    (first_i),
    .last_i     (last_i),
    .cmd_valid_o(f_valid),
    .cmd_ready_i(f_ready),
    .cmd_o      (f_cmd)
  );

  spiee_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .ready_o(f_ready),
    .data_i (f_cmd),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .data_o (q_cmd)
  );

  spiee_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_pop),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .action_o    (action_o),
    .tx_byte_o   (tx_byte_o),
    .end_of_run_o(end_of_run_o)
  );

endmodule

@@ sv/spiee_front.sv @@
// front end: accepts requests and status replies, tracks transfer state
// and classifies each transaction into at most one command; uses spiee_pkg
module spiee_front #(
  parameter int unsigned PAGE_BYTES = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        data_i,
  input  logic              first_i,
  input  logic              last_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output spiee_pkg::cmd_t   cmd_o
);

  localparam int unsigned PageShift  = $clog2(PAGE_BYTES);
  localparam bit          PagePow2   = ((1 << PageShift) == PAGE_BYTES);
  localparam int unsigned RecipShift = 16 + PageShift;
  localparam int unsigned ProdW      = RecipShift + 17;
  localparam longint unsigned RecipMul =
    ((64'd1 << RecipShift) + PAGE_BYTES - 1) / PAGE_BYTES;

  logic             awaiting_q, awaiting_d;
  logic             select_q, select_d;
  spiee_pkg::op_e   pend_kind_q, pend_kind_d;
  logic [15:0]      pend_addr_q, pend_addr_d;
  logic [7:0]       pend_byte_q, pend_byte_d;
  logic             pend_end_q, pend_end_d;
  logic             accept;
  logic             page_hit;
  spiee_pkg::op_e   op;

  assign op         = spiee_pkg::op_e'(op_i);
  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  generate
    if (PagePow2) begin : g_page_mask
      assign page_hit = (address_i[PageShift-1:0] == '0);
    end else begin : g_page_recip
      logic [ProdW-1:0] prod;
      logic [15:0]      quot;
      logic [ProdW-1:0] back;
      assign prod = ProdW'(address_i) * ProdW'(RecipMul);
      assign quot = 16'(prod >> RecipShift);
      assign back = ProdW'(quot) * ProdW'(PAGE_BYTES);
      assign page_hit = (back == ProdW'(address_i));
    end
  endgenerate

  always_comb begin
    awaiting_d  = awaiting_q;
    select_d    = select_q;
    pend_kind_d = pend_kind_q;
    pend_addr_d = pend_addr_q;
    pend_byte_d = pend_byte_q;
    pend_end_d  = pend_end_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '{kind: spiee_pkg::CMD_SHIFT, pre_rel: 1'b0, end_rel: 1'b0,
                    addr: pend_addr_q, data: pend_byte_q};
    if (accept) begin
      if (op == spiee_pkg::OP_STATUS) begin
        if (awaiting_q) begin
          cmd_valid_o = 1'b1;
          if (data_i[spiee_pkg::WIP_BIT]) begin
            cmd_o.kind = spiee_pkg::CMD_POLL;
            select_d   = 1'b0;
          end else begin
            awaiting_d    = 1'b0;
            cmd_o.end_rel = pend_end_q;
            unique case (pend_kind_q)
              spiee_pkg::OP_WRITE_BYTE: begin
                cmd_o.kind = spiee_pkg::CMD_WRITE;
                select_d   = !pend_end_q;
              end
              spiee_pkg::OP_READ_BYTE: begin
                cmd_o.kind = spiee_pkg::CMD_READ;
                select_d   = !pend_end_q;
              end
              default: begin
                cmd_o.kind = spiee_pkg::CMD_ERASE;
                select_d   = 1'b0;
              end
            endcase
          end
        end
      end else if (!awaiting_q) begin
        cmd_valid_o = 1'b1;
        if (op == spiee_pkg::OP_CHIP_ERASE || first_i || !select_q ||
            pend_kind_q != op ||
            (op == spiee_pkg::OP_WRITE_BYTE && page_hit)) begin
          cmd_o.kind    = spiee_pkg::CMD_POLL;
          cmd_o.pre_rel = select_q;
          pend_kind_d   = op;
          pend_addr_d   = address_i;
          pend_byte_d   = data_i;
          pend_end_d    = last_i;
          awaiting_d    = 1'b1;
          select_d      = 1'b0;
        end else begin
          cmd_o.kind    = spiee_pkg::CMD_SHIFT;
          cmd_o.end_rel = last_i;
          cmd_o.data    = (op == spiee_pkg::OP_WRITE_BYTE) ? data_i : 8'h00;
          select_d      = !last_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q  <= 1'b0;
      select_q    <= 1'b0;
      pend_kind_q <= spiee_pkg::OP_WRITE_BYTE;
      pend_addr_q <= '0;
      pend_byte_q <= '0;
      pend_end_q  <= 1'b0;
    end else begin
      awaiting_q  <= awaiting_d;
      select_q    <= select_d;
      pend_kind_q <= pend_kind_d;
      pend_addr_q <= pend_addr_d;
      pend_byte_q <= pend_byte_d;
      pend_end_q  <= pend_end_d;
    end
  end

endmodule

@@ sv/spiee_cmd_fifo.sv @@
// short command queue between front end and back end
// uses spiee_pkg for the command type and depth
module spiee_cmd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            ready_o,
  input  spiee_pkg::cmd_t data_i,
  output logic            valid_o,
  input  logic            pop_i,
  output spiee_pkg::cmd_t data_o
);

  localparam int unsigned Depth = spiee_pkg::CMD_Q_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  spiee_pkg::cmd_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/spiee_back.sv @@
// back end: expands one command into its sequence of spi byte actions,
// one output transaction per step; uses spiee_pkg
module spiee_back #(
  parameter int unsigned ADDR_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  spiee_pkg::cmd_t cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      action_o,
  output logic [7:0]      tx_byte_o,
  output logic            end_of_run_o
);

  localparam logic [15:0] AddrMask =
    (ADDR_BITS >= 16) ? 16'hFFFF : 16'((1 << ADDR_BITS) - 1);
  localparam bit WideAddr = (ADDR_BITS > 8);

  logic            busy_q, busy_d;
  spiee_pkg::cmd_t cmd_q, cmd_d;
  logic [2:0]      step_q, step_d;
  logic [2:0]      step_next;
  logic [2:0]      step_first;
  logic [15:0]     addr_m;
  spiee_pkg::action_e act;
  logic [7:0]      txb;
  logic            last;
  logic            out_fire;
  logic            load;

  assign addr_m = cmd_q.addr & AddrMask;

  always_comb begin
    act  = spiee_pkg::ACT_SHIFT;
    txb  = 8'h00;
    last = 1'b0;
    unique case (cmd_q.kind)
      spiee_pkg::CMD_POLL: begin
        unique case (step_q)
          3'd0: act = spiee_pkg::ACT_RELEASE;
          3'd1: txb = spiee_pkg::SPI_RDSR;
          3'd2: txb = 8'h00;
          3'd3: act = spiee_pkg::ACT_RELEASE;
          default: begin
            act  = spiee_pkg::ACT_AWAIT;
            last = 1'b1;
          end
        endcase
      end
      spiee_pkg::CMD_WRITE: begin
        unique case (step_q)
          3'd0: txb = spiee_pkg::SPI_WREN;
          3'd1: act = spiee_pkg::ACT_RELEASE;
          3'd2: txb = spiee_pkg::SPI_WRITE;
          3'd3: txb = addr_m[15:8];
          3'd4: txb = addr_m[7:0];
          3'd5: begin
            txb  = cmd_q.data;
            last = !cmd_q.end_rel;
          end
          default: begin
            act  = spiee_pkg::ACT_RELEASE;
            last = 1'b1;
          end
        endcase
      end
      spiee_pkg::CMD_READ: begin
        unique case (step_q)
          3'd0: txb = spiee_pkg::SPI_READ;
          3'd1: txb = addr_m[15:8];
          3'd2: txb = addr_m[7:0];
          3'd3: begin
            txb  = 8'h00;
            last = !cmd_q.end_rel;
          end
          default: begin
            act  = spiee_pkg::ACT_RELEASE;
            last = 1'b1;
          end
        endcase
      end
      spiee_pkg::CMD_ERASE: begin
        unique case (step_q)
          3'd0: txb = spiee_pkg::SPI_WREN;
          3'd1: act = spiee_pkg::ACT_RELEASE;
          3'd2: txb = spiee_pkg::SPI_CE;
          default: begin
            act  = spiee_pkg::ACT_RELEASE;
            last = 1'b1;
          end
        endcase
      end
      default: begin
        if (step_q == 3'd0) begin
          txb  = cmd_q.data;
          last = !cmd_q.end_rel;
        end else begin
          act  = spiee_pkg::ACT_RELEASE;
          last = 1'b1;
        end
      end
    endcase
  end

  // narrow addresses send a single address byte
  always_comb begin
    step_next = step_q + 3'd1;
    if (!WideAddr &&
        ((cmd_q.kind == spiee_pkg::CMD_WRITE && step_q == 3'd2) ||
         (cmd_q.kind == spiee_pkg::CMD_READ && step_q == 3'd0))) begin
      step_next = step_q + 3'd2;
    end
    step_first = (cmd_i.kind == spiee_pkg::CMD_POLL && !cmd_i.pre_rel) ? 3'd1 : 3'd0;
  end

  assign out_valid_o  = busy_q;
  assign action_o     = act;
  assign tx_byte_o    = txb;
  assign end_of_run_o = last;
  assign out_fire     = busy_q && out_ready_i;
  assign cmd_ready_o  = !busy_q || (out_ready_i && last);
  assign load         = cmd_valid_i && cmd_ready_o;

  always_comb begin
    busy_d = busy_q;
    cmd_d  = cmd_q;
    step_d = step_q;
    if (load) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      step_d = step_first;
    end else if (out_fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

`ifndef SYNTH
  a_await_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == spiee_pkg::ACT_AWAIT |-> end_of_run_o)
    else $error("await action not last of run");
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= 3'd6)
    else $error("step counter out of range");
  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o != spiee_pkg::ACT_SHIFT |-> tx_byte_o == 8'h00)
    else $error("nonzero byte on non-shift action");
  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && !busy_q |=> busy_q)
    else $error("queued command not taken while idle");
`endif

endmodule
